>>> hw/rtl/wto_pkg.sv
package wto_pkg;

    localparam int TABLE_SIZE_DEF = 1024;

    localparam int FREQ_W   = 24;
    localparam int SCALE_W  = 40;
    localparam int ADDR_W   = 10;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int FRAC_W   = 16;

    // step_scale is split into two halves so that each partial product stays narrow
    localparam int SCALE_HALF_W = SCALE_W / 2;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [FREQ_W-1:0]  DEFAULT_FREQ_RST = '0;
    localparam logic [SCALE_W-1:0] STEP_SCALE_RST   = 40'd6382652533;

    // power of two, so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_FREQ = 1'b0,
        CFG_STEP_SCALE   = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_WRITE  = 1'b1
    } t_action;

    // one classified transaction between front and back
    typedef struct packed {
        t_action                     action;
        logic [ADDR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0]  value;
        logic [PHASE_W-1:0]          step;
    } t_item;

endpackage

>>> hw/rtl/wto_front.sv
module wto_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic                              i_use_default,
    input  logic signed [wto_pkg::FREQ_W-1:0] i_freq_hz,
    input  logic [wto_pkg::ADDR_W-1:0]        i_table_addr,
    input  logic signed [wto_pkg::SAMPLE_W-1:0] i_table_value,
    input  logic                              i_cfg_we,
    input  logic [wto_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wto_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_push,
    output wto_pkg::t_item                    o_item,
    input  logic                              i_full
);

    localparam int PROD_W = wto_pkg::FREQ_W + wto_pkg::SCALE_HALF_W + 1;
    localparam int HI_W   = wto_pkg::PHASE_W + 24 - wto_pkg::SCALE_HALF_W;
    localparam int LO_W   = PROD_W - wto_pkg::SCALE_HALF_W;
    localparam int SUM_LSB = 24 - wto_pkg::SCALE_HALF_W;

    logic signed [wto_pkg::FREQ_W-1:0]  r_default_freq;
    logic [wto_pkg::SCALE_W-1:0]        r_step_scale;

    logic                               r_f1_valid;
    wto_pkg::t_action                   r_f1_action;
    logic                               r_f1_use_def;
    logic signed [wto_pkg::FREQ_W-1:0]  r_f1_freq;
    logic [wto_pkg::ADDR_W-1:0]         r_f1_addr;
    logic signed [wto_pkg::SAMPLE_W-1:0] r_f1_value;

    logic                               r_f2_valid;
    wto_pkg::t_action                   r_f2_action;
    logic [wto_pkg::ADDR_W-1:0]         r_f2_addr;
    logic signed [wto_pkg::SAMPLE_W-1:0] r_f2_value;
    logic [HI_W-1:0]                    r_f2_hi;
    logic [LO_W-1:0]                    r_f2_lo;

    logic                               fen;
    logic signed [wto_pkg::FREQ_W-1:0]  freq_sel;
    logic signed [PROD_W-1:0]           prod_lo;
    logic signed [PROD_W-1:0]           prod_hi;
    logic [HI_W-1:0]                    step_sum;

    assign fen     = !(r_f2_valid && i_full);
    assign o_stall = !fen;

    assign freq_sel = r_f1_use_def ? r_default_freq : r_f1_freq;
    assign prod_lo  = freq_sel
                    * $signed({1'b0, r_step_scale[wto_pkg::SCALE_HALF_W-1:0]});
    assign prod_hi  = freq_sel
                    * $signed({1'b0, r_step_scale[wto_pkg::SCALE_W-1:wto_pkg::SCALE_HALF_W]});

    // the high partial product has nothing below its shift, so bits below it never carry
    assign step_sum = r_f2_hi + {{(HI_W-LO_W){r_f2_lo[LO_W-1]}}, r_f2_lo};

    assign o_push        = r_f2_valid && !i_full;
    assign o_item.action = r_f2_action;
    assign o_item.addr   = r_f2_addr;
    assign o_item.value  = r_f2_value;
    assign o_item.step   = step_sum[SUM_LSB +: wto_pkg::PHASE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_freq <= wto_pkg::DEFAULT_FREQ_RST;
            r_step_scale   <= wto_pkg::STEP_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (wto_pkg::t_cfg_reg'(i_cfg_index))
                wto_pkg::CFG_DEFAULT_FREQ: begin
                    r_default_freq <= i_cfg_data[wto_pkg::FREQ_W-1:0];
                end
                wto_pkg::CFG_STEP_SCALE: begin
                    r_step_scale <= i_cfg_data[wto_pkg::SCALE_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (fen) begin
            r_f1_valid <= i_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_f1_action  <= wto_pkg::t_action'(i_action);
            r_f1_use_def <= i_use_default;
            r_f1_freq    <= i_freq_hz;
            r_f1_addr    <= i_table_addr;
            r_f1_value   <= i_table_value;

            r_f2_action  <= r_f1_action;
            r_f2_addr    <= r_f1_addr;
            r_f2_value   <= r_f1_value;
            r_f2_hi      <= prod_hi[HI_W-1:0];
            r_f2_lo      <= prod_lo[PROD_W-1:wto_pkg::SCALE_HALF_W];
        end
    end

endmodule

>>> hw/rtl/wto_queue.sv
module wto_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wto_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output wto_pkg::t_item o_head
);

    wto_pkg::t_item                   r_slot [wto_pkg::QUEUE_DEPTH];
    logic [wto_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [wto_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [wto_pkg::QUEUE_CNT_W-1:0]  r_count;
    logic [wto_pkg::QUEUE_CNT_W-1:0]  n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full       = (r_count == wto_pkg::QUEUE_CNT_W'(wto_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + wto_pkg::QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - wto_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + wto_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + wto_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/wto_back.sv
module wto_back #(
    parameter int TABLE_SIZE = wto_pkg::TABLE_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_head_valid,
    input  wto_pkg::t_item                      i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [wto_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int POS_W  = wto_pkg::PHASE_W + IDX_W + 1;
    localparam int DIFF_W = wto_pkg::SAMPLE_W + 1;
    localparam int MUL_W  = DIFF_W + wto_pkg::FRAC_W + 1;
    localparam int PART_W = MUL_W - wto_pkg::FRAC_W;

    logic signed [wto_pkg::SAMPLE_W-1:0] r_table [TABLE_SIZE];

    logic [wto_pkg::PHASE_W-1:0]         r_phase;
    logic                                r_s1_valid;
    logic [wto_pkg::FRAC_W-1:0]          r_s1_frac;
    logic signed [wto_pkg::SAMPLE_W-1:0] r_rd_a;
    logic signed [wto_pkg::SAMPLE_W-1:0] r_rd_b;
    logic                                r_s2_valid;
    logic signed [wto_pkg::SAMPLE_W-1:0] r_s2_a;
    logic signed [MUL_W-1:0]             r_s2_prod;
    logic                                r_out_valid;
    logic signed [wto_pkg::SAMPLE_W-1:0] r_out_sample;

    logic                                en;
    logic                                take_sample;
    logic                                take_write;
    logic                                addr_ok;
    logic [wto_pkg::PHASE_W-1:0]         rd_pos;
    logic [POS_W-1:0]                    pos;
    logic [IDX_W-1:0]                    idx;
    logic [IDX_W-1:0]                    nxt;
    logic [wto_pkg::FRAC_W-1:0]          frac;
    logic signed [DIFF_W-1:0]            diff;
    logic signed [MUL_W-1:0]             mul;
    logic signed [PART_W-1:0]            sum;

    // the whole back pipeline holds while the output register is blocked
    assign en          = !(r_out_valid && i_stall);
    assign o_pop       = en && i_head_valid;
    assign take_sample = o_pop && (i_head.action == wto_pkg::ACT_SAMPLE);
    assign take_write  = o_pop && (i_head.action == wto_pkg::ACT_WRITE);
    assign addr_ok     = (32'(i_head.addr) < 32'(TABLE_SIZE));

    // table is read backwards: position is the negated phase
    assign rd_pos = wto_pkg::PHASE_W'(0) - r_phase;
    assign pos    = POS_W'(rd_pos) * POS_W'(TABLE_SIZE);
    assign idx    = pos[wto_pkg::PHASE_W +: IDX_W];
    assign frac   = pos[wto_pkg::FRAC_W +: wto_pkg::FRAC_W];
    assign nxt    = (idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx + IDX_W'(1);

    assign diff = {r_rd_b[wto_pkg::SAMPLE_W-1], r_rd_b} - {r_rd_a[wto_pkg::SAMPLE_W-1], r_rd_a};
    assign mul  = diff * $signed({1'b0, r_s1_frac});
    // floor of the product over 2^16, then add the base entry
    assign sum  = {{(PART_W-wto_pkg::SAMPLE_W){r_s2_a[wto_pkg::SAMPLE_W-1]}}, r_s2_a}
                + r_s2_prod[MUL_W-1:wto_pkg::FRAC_W];

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= take_sample;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (take_sample) begin
                r_phase <= r_phase + i_head.step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_write && addr_ok) begin
            r_table[IDX_W'(i_head.addr)] <= i_head.value;
        end
        if (en) begin
            r_rd_a <= r_table[idx];
            r_rd_b <= r_table[nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_frac    <= frac;
            r_s2_a       <= r_rd_a;
            r_s2_prod    <= mul;
            r_out_sample <= sum[wto_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

>>> hw/rtl/wavetable_oscillator.sv
// Wavetable oscillator with linear interpolation between adjacent table entries.
// Input channel (i_valid / o_stall): each transaction is either a table write
// (i_action = 1, stores i_table_value at i_table_addr, no result) or a sample
// request (i_action = 0, one result on the output channel). The frequency of a
// request comes from i_freq_hz, or from the default_freq register when
// i_use_default is set. Output channel (o_valid / i_stall) carries o_sample.
// Configuration: i_cfg_we with i_cfg_index 0 (default_freq) or 1 (step_scale),
// written while the block is idle.
// Throughput: one transaction per cycle while the output is not stalled, set by
// the phase add and the two table reads per cycle in the back end. From
// acceptance to o_valid a sample passes the input register, loaded at the
// accepting edge, then the partial-product register, queue slot, table read,
// interpolation multiply and output register.
// A four-entry queue separates the step calculation from the table back end;
// when i_stall holds the output, the back end freezes and the queue fills, and
// only then does o_stall rise. Reset clears the phase and both registers to
// their defaults and empties the pipeline; the table is not cleared, so every
// entry must be written before a request reads it.
module wavetable_oscillator #(
    parameter int TABLE_SIZE = wto_pkg::TABLE_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_action,
    input  logic                                i_use_default,
    input  logic signed [wto_pkg::FREQ_W-1:0]   i_freq_hz,
    input  logic [wto_pkg::ADDR_W-1:0]          i_table_addr,
    input  logic signed [wto_pkg::SAMPLE_W-1:0] i_table_value,
    input  logic                                i_cfg_we,
    input  logic [wto_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wto_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [wto_pkg::SAMPLE_W-1:0] o_sample
);

    logic           push;
    wto_pkg::t_item push_item;
    logic           full;
    logic           pop;
    logic           head_valid;
    wto_pkg::t_item head;

    wto_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_use_default (i_use_default),
        .i_freq_hz     (i_freq_hz),
        .i_table_addr  (i_table_addr),
        .i_table_value (i_table_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_item        (push_item),
        .i_full        (full)
    );

    wto_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    wto_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample)
    );

endmodule

>>> hw/rtl/wto_checker.sv
module wto_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [wto_pkg::SAMPLE_W-1:0] o_sample
);

    // a blocked result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("output transaction changed while stalled");

    // a result leaves only through a completed transaction
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("output transaction dropped without acceptance");

    // reset empties the back end
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

    // reset empties the front end, so input is taken at once
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind wavetable_oscillator wto_checker u_wto_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_sample (o_sample)
);

>>> tb/sv/wavetable_oscillator_tb.sv
module wavetable_oscillator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wto_pkg::*;

    localparam int IDX_LSB  = PHASE_W - ADDR_W;
    localparam int FRAC_LSB = IDX_LSB - FRAC_W;
    localparam int DRAIN_CAP = 50000;

    typedef struct {
        t_action                     action;
        logic                        use_def;
        logic signed [FREQ_W-1:0]    freq;
        logic [ADDR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0]  value;
    } osc_req_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic                        i_action = 1'b0;
    logic                        i_use_default = 1'b0;
    logic signed [FREQ_W-1:0]    i_freq_hz = '0;
    logic [ADDR_W-1:0]           i_table_addr = '0;
    logic signed [SAMPLE_W-1:0]  i_table_value = '0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_sample;

    wavetable_oscillator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_use_default (i_use_default),
        .i_freq_hz     (i_freq_hz),
        .i_table_addr  (i_table_addr),
        .i_table_value (i_table_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    osc_req_t                    pending_req_q[$];
    logic signed [SAMPLE_W-1:0]  expected_sample_q[$];

    // register copies, changed only while the block is idle
    logic signed [FREQ_W-1:0]    cfg_default_freq = DEFAULT_FREQ_RST;
    logic [SCALE_W-1:0]          cfg_step_scale = STEP_SCALE_RST;

    // oscillator state as seen at acceptance
    logic [PHASE_W-1:0]          osc_phase = '0;
    logic signed [SAMPLE_W-1:0]  table_model [TABLE_SIZE_DEF];

    // stimulus planning: phase tracked ahead of the driver, entries written so far
    logic [PHASE_W-1:0]          plan_phase = '0;
    bit                          written_map [TABLE_SIZE_DEF];

    bit quiet = 1'b0;
    int errors = 0;

    function automatic logic [PHASE_W-1:0] phase_step(logic signed [FREQ_W-1:0] f,
                                                      logic [SCALE_W-1:0] sc);
        longint fl, sl;
        logic [63:0] p;
        fl = f;
        sl = sc;
        p = fl * sl;
        return p[24 +: PHASE_W];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] interp_at(logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] rd;
        logic [ADDR_W-1:0] idx, nxt;
        longint a, b, frac, prod;
        rd = -ph;
        idx = rd[PHASE_W-1:IDX_LSB];
        nxt = idx + 1'b1;
        frac = rd[FRAC_LSB +: FRAC_W];
        a = table_model[idx];
        b = table_model[nxt];
        prod = (b - a) * frac;
        return SAMPLE_W'(a + (prod >>> FRAC_W));
    endfunction

    task automatic osc_accept(osc_req_t req);
        logic signed [FREQ_W-1:0] f;
        if (req.action == ACT_WRITE) begin
            table_model[req.addr] = req.value;
        end else begin
            expected_sample_q.push_back(interp_at(osc_phase));
            f = req.use_def ? cfg_default_freq : req.freq;
            osc_phase = osc_phase + phase_step(f, cfg_step_scale);
        end
    endtask

    task automatic push_write(logic [ADDR_W-1:0] addr, logic signed [SAMPLE_W-1:0] value);
        osc_req_t req;
        req.action = ACT_WRITE;
        req.use_def = $urandom_range(0, 1);
        req.freq = FREQ_W'($urandom);
        req.addr = addr;
        req.value = value;
        written_map[addr] = 1'b1;
        pending_req_q.push_back(req);
    endtask

    task automatic push_sample(logic use_def, logic signed [FREQ_W-1:0] freq);
        osc_req_t req;
        logic [PHASE_W-1:0] rd;
        logic [ADDR_W-1:0] idx;
        rd = -plan_phase;
        idx = rd[PHASE_W-1:IDX_LSB];
        // fill both entries the read will touch before it happens
        for (int k = 0; k < 2; k++) begin
            if (!written_map[idx])
                push_write(idx, SAMPLE_W'($urandom));
            idx = idx + 1'b1;
        end
        req.action = ACT_SAMPLE;
        req.use_def = use_def;
        req.freq = freq;
        req.addr = ADDR_W'($urandom);
        req.value = SAMPLE_W'($urandom);
        pending_req_q.push_back(req);
        plan_phase = plan_phase + phase_step(use_def ? cfg_default_freq : freq,
                                             cfg_step_scale);
    endtask

    task automatic rand_items(int n);
        logic signed [FREQ_W-1:0] f;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 30) begin
                push_write(ADDR_W'($urandom), SAMPLE_W'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0:       f = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                    1, 2, 3,
                    4:       f = FREQ_W'($urandom);
                    default: f = FREQ_W'($signed($urandom_range(0, 4000)) - 2000);
                endcase
                push_sample($urandom_range(0, 3) == 0, f);
            end
        end
    endtask

    task automatic drain();
        int n;
        n = 0;
        while ((pending_req_q.size() != 0 || i_valid || expected_sample_q.size() != 0)
               && n < DRAIN_CAP) begin
            @(negedge i_clk);
            n++;
        end
        if (n >= DRAIN_CAP) begin
            $error("drain timed out with %0d samples outstanding", expected_sample_q.size());
            errors++;
        end
        // let trailing table writes settle
        repeat (12) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg sel, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_DEFAULT_FREQ)
            cfg_default_freq = data[FREQ_W-1:0];
        else
            cfg_step_scale = data[SCALE_W-1:0];
        @(negedge i_clk);
    endtask

    // driver
    osc_req_t cur_req;
    int src_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap = 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid)
                osc_accept(cur_req);
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (!quiet && pending_req_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 13);
                i_valid <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
                cur_req = pending_req_q.pop_front();
                i_valid <= 1'b1;
                i_action <= cur_req.action;
                i_use_default <= cur_req.use_def;
                i_freq_hz <= cur_req.freq;
                i_table_addr <= cur_req.addr;
                i_table_value <= cur_req.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and output back-pressure
    int snk_gap = 0;
    int hold_cnt = 0;
    int n_results = 0;
    bit held_once = 1'b0;
    bit stall_next;
    logic signed [SAMPLE_W-1:0] exp_sample;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_sample_q.size() == 0) begin
                    $error("unexpected sample transaction, actual %0d", o_sample);
                    errors++;
                end else begin
                    exp_sample = expected_sample_q.pop_front();
                    if (o_sample !== exp_sample) begin
                        $error("sample: expected %0d, actual %0d", exp_sample, o_sample);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                stall_next = 1'b1;
            end else if (!held_once && !quiet && n_results >= 200) begin
                // hold off long enough for the block to fill and stall its input
                held_once = 1'b1;
                hold_cnt = 400;
                stall_next = 1'b1;
            end else if (snk_gap > 0) begin
                snk_gap--;
                stall_next = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 13);
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            i_stall <= stall_next;
        end
    end

    initial begin
        #2_000_000;
        $display("wavetable_oscillator: mismatch");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: phase zero reads entry 0 exactly, then a tiny step lands on
        // the last entry so the next read wraps to entry 0
        push_write(10'd0, 16'sh7FFF);
        push_write(10'd1, 16'sh8000);
        push_sample(1'b0, 24'sd1);
        push_write(10'd1023, 16'sh8000);
        push_sample(1'b0, 24'sh800000);
        push_sample(1'b1, 24'sh7FFFFF);
        push_sample(1'b0, 24'sh7FFFFF);
        push_write(10'd1023, 16'sh7FFF);
        push_write(10'd512, 16'sh0000);
        push_sample(1'b0, 24'sd0);
        push_sample(1'b0, -24'sd1);
        push_sample(1'b0, -24'sd256);
        push_sample(1'b1, 24'sh800000);
        push_sample(1'b0, 24'sd25600);
        push_sample(1'b0, 24'sd0);
        drain();

        cfg_write(CFG_DEFAULT_FREQ, {16'($urandom), 24'h800000});
        cfg_write(CFG_STEP_SCALE, {SCALE_W{1'b1}});
        push_sample(1'b1, 24'sd0);
        push_sample(1'b1, 24'sh7FFFFF);
        rand_items(150);
        drain();

        cfg_write(CFG_DEFAULT_FREQ, {16'($urandom), 24'h7FFFFF});
        cfg_write(CFG_STEP_SCALE, '0);
        rand_items(100);
        drain();

        for (int p = 0; p < 3; p++) begin
            cfg_write(CFG_DEFAULT_FREQ, CFG_DATA_W'({$urandom, $urandom}));
            cfg_write(CFG_STEP_SCALE, $urandom_range(0, 1) ? CFG_DATA_W'({$urandom, $urandom})
                                                           : STEP_SCALE_RST);
            rand_items(150);
            drain();
        end

        // final stretch without idling on either side
        quiet = 1'b1;
        cfg_write(CFG_DEFAULT_FREQ, CFG_DATA_W'($signed($urandom_range(0, 4000)) - 2000));
        cfg_write(CFG_STEP_SCALE, STEP_SCALE_RST);
        rand_items(200);
        drain();

        if (errors == 0)
            $display("wavetable_oscillator: match");
        else
            $display("wavetable_oscillator: mismatch");
        $finish;
    end

endmodule

>>> wavetable_oscillator.f
hw/rtl/wto_pkg.sv
hw/rtl/wto_front.sv
hw/rtl/wto_queue.sv
hw/rtl/wto_back.sv
hw/rtl/wavetable_oscillator.sv
hw/rtl/wto_checker.sv
tb/sv/wavetable_oscillator_tb.sv
